@@ design/lsfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_pkg - shared types and constants of the LED strip frame chunker
// Command and chunk plan records passed between the front, queue and back.
// ----------------------------------------------------------------------------
package lsfc_pkg;

	// Counts inside one chunk; wide enough for the largest chunk length (64)
	localparam int CNT_W = 7;

	// Header bits [7:5] of every LED word, above the five brightness bits
	localparam logic [2:0] LED_HDR = 3'b111;

	// Stop-word divisor is 64: rounding up adds 63 before the shift
	localparam int STOP_SHIFT = 6;
	localparam logic [17:0] STOP_ROUND = 18'd63;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  brightness;
		logic [15:0] num_leds;
		logic        following;
	} cmd_t;

	typedef struct packed {
		logic [31:0]      led_word;
		logic             start;
		logic [CNT_W-1:0] leds;
		logic [CNT_W-1:0] stops;
		logic             marker;
		logic             status;
	} plan_t;

endpackage

@@ design/led_strip_frame_chunker.sv @@
`timescale 1ns / 1ps
// A chunk's first word passes the command register, the plan queue, the emitter's
// plan register and the output register. The emitter sends one word per cycle while the
// receiver is ready and takes the next plan only after the last word of a chunk; the
// planner accepts one command per cycle while the two-entry plan queue has room.
// Reset: arst_n clears handshakes and strip state (start frame due, counters zero);
// no clearing pass, the block can take a command as soon as reset is released.
// ----------------------------------------------------------------------------
// led_strip_frame_chunker - colour commands to chunks of serial LED strip words
// Each command yields a start frame when due, repeated LED words and stop words,
// split across chunks of CHUNK_WORDS words for long strips.
// ----------------------------------------------------------------------------
module led_strip_frame_chunker #(
	parameter int CHUNK_WORDS = 32  // words per chunk, 4 to 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // red[7:0], green[15:8], blue[23:16],
	                               // brightness[31:24], num_leds[47:32]
	input  logic        s_tuser,   // following
	// word stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // word
	output logic        m_tlast,   // last word of the chunk
	output logic [1:0]  m_tuser    // word_valid[0], status[1]
);
	import lsfc_pkg::*;

	cmd_t  cmd;
	plan_t plan;
	plan_t q_data;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_empty;

	// unpack the command transaction
	always_comb begin
		cmd.red        = s_tdata[7:0];
		cmd.green      = s_tdata[15:8];
		cmd.blue       = s_tdata[23:16];
		cmd.brightness = s_tdata[31:24];
		cmd.num_leds   = s_tdata[47:32];
		cmd.following  = s_tuser;
	end

	// front: holds the command, plans the chunk and owns the strip state
	lsfc_front #(
		.CHUNK_WORDS(CHUNK_WORDS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.cmd     (cmd),
		.q_full  (q_full),
		.push    (push),
		.plan    (plan)
	);

	// short queue so planning and emission stall independently
	lsfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(plan),
		.full     (q_full),
		.pop      (pop),
		.pop_data (q_data),
		.empty    (q_empty)
	);

	// back: steps through the plan, one word per transaction
	lsfc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

@@ design/lsfc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_front - command intake and chunk planning
// Holds one command, works out the chunk layout and updates the strip state.
// ----------------------------------------------------------------------------
module lsfc_front #(
	parameter int CHUNK_WORDS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  lsfc_pkg::cmd_t       cmd,
	input  logic                 q_full,
	output logic                 push,
	output lsfc_pkg::plan_t      plan
);
	import lsfc_pkg::*;

	localparam logic [CNT_W-1:0] CW_C   = CNT_W'(CHUNK_WORDS);
	localparam logic [CNT_W-1:0] CWM1_C = CNT_W'(CHUNK_WORDS - 1);

	logic        have_q;
	cmd_t        cmd_q;
	logic        sfd_q;
	logic [15:0] sent_q;
	logic [15:0] rem_q;

	logic             idle;
	logic [15:0]      n;
	logic [15:0]      sent_eff;
	logic [CNT_W-1:0] space;
	logic [17:0]      sum;
	logic [11:0]      stops_raw;
	logic [CNT_W-1:0] stops_cap;
	logic [16:0]      need;
	logic             fit;
	logic [15:0]      nm1;
	logic [CNT_W-1:0] chunk;
	logic [CNT_W-1:0] stops;
	logic [15:0]      rem_next;
	logic [16:0]      sent_sum;
	logic [15:0]      sent_next;
	logic             sfd_next;

	assign push     = have_q && !q_full;
	assign s_tready = !have_q || push;

	always_comb begin
		idle      = (cmd_q.num_leds == 16'd0) && !sfd_q && !cmd_q.following;
		n         = (rem_q != 16'd0) ? rem_q : cmd_q.num_leds;
		sent_eff  = sfd_q ? 16'd0 : sent_q;
		space     = sfd_q ? CW_C - CNT_W'(1) : CW_C;
		sum       = 18'(n) + 18'(sent_eff) + STOP_ROUND;
		stops_raw = sum[17:STOP_SHIFT];
		if (cmd_q.following) begin
			stops_cap = '0;
		end else if (stops_raw > 12'(CWM1_C)) begin
			stops_cap = CWM1_C;
		end else begin
			stops_cap = stops_raw[CNT_W-1:0];
		end
		need = 17'(n) + 17'(stops_cap);
		fit  = need <= 17'(space);
		nm1  = (n == 16'd0) ? 16'd0 : n - 16'd1;
		if (fit) begin
			chunk = n[CNT_W-1:0];
			stops = stops_cap;
		end else begin
			chunk = (nm1 > 16'(space)) ? space : nm1[CNT_W-1:0];
			stops = '0;
		end
		rem_next  = n - 16'(chunk);
		sent_sum  = 17'(sent_eff) + 17'(chunk);
		sent_next = sent_sum[16] ? 16'hFFFF : sent_sum[15:0];
		sfd_next  = (rem_next == 16'd0) && !cmd_q.following;

		plan.led_word = {cmd_q.red, cmd_q.green, cmd_q.blue, LED_HDR,
		                 cmd_q.brightness[7:3]};
		if (idle) begin
			plan.start  = 1'b0;
			plan.leds   = '0;
			plan.stops  = '0;
			plan.marker = 1'b1;
			plan.status = 1'b0;
		end else begin
			plan.start  = sfd_q;
			plan.leds   = chunk;
			plan.stops  = stops;
			plan.marker = !sfd_q && (chunk == '0) && (stops == '0);
			plan.status = rem_next != 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			sfd_q  <= 1'b1;
			sent_q <= '0;
			rem_q  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				have_q <= 1'b1;
			end else if (push) begin
				have_q <= 1'b0;
			end
			if (push && !idle) begin
				sfd_q  <= sfd_next;
				sent_q <= sent_next;
				rem_q  <= rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q <= cmd;
		end
	end

	// a pending remainder never comes with a start frame due
	a_rem_no_start: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != 16'd0) |-> !sfd_q)
		else $error("start frame due while LEDs remain");

	// a planned chunk never exceeds the chunk length
	a_chunk_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ((8'(plan.leds) + 8'(plan.stops) + 8'(plan.start)) <= 8'(CHUNK_WORDS)))
		else $error("chunk plan longer than chunk");

endmodule

@@ design/lsfc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_queue - two-entry plan queue
// Decouples chunk planning from word emission.
// ----------------------------------------------------------------------------
module lsfc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lsfc_pkg::plan_t  push_data,
	output logic             full,
	input  logic             pop,
	output lsfc_pkg::plan_t  pop_data,
	output logic             empty
);
	import lsfc_pkg::*;

	plan_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty) && (cnt_q != 2'd3))
		else $error("plan queue overrun or underrun");

endmodule

@@ design/lsfc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_back - word emitter
// Walks a chunk plan and sends one word per transaction through an output register.
// ----------------------------------------------------------------------------
module lsfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  lsfc_pkg::plan_t  q_data,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,
	output logic             m_tlast,
	output logic [1:0]       m_tuser
);
	import lsfc_pkg::*;

	logic             busy_q;
	logic             start_q;
	logic [CNT_W-1:0] leds_q;
	logic [CNT_W-1:0] stops_q;
	logic             marker_q;
	logic             status_q;
	logic [31:0]      led_word_q;

	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic        out_last_q;
	logic        out_wv_q;
	logic        out_status_q;

	logic        advance;
	logic [31:0] nx_word;
	logic        nx_wv;
	logic        nx_last;

	assign advance = !out_valid_q || m_tready;
	assign pop     = !busy_q && !q_empty;

	always_comb begin
		nx_word = '0;
		nx_wv   = 1'b1;
		nx_last = 1'b0;
		if (marker_q) begin
			nx_wv   = 1'b0;
			nx_last = 1'b1;
		end else if (start_q) begin
			nx_last = (leds_q == '0) && (stops_q == '0);
		end else if (leds_q != '0) begin
			nx_word = led_word_q;
			nx_last = (leds_q == CNT_W'(1)) && (stops_q == '0);
		end else begin
			nx_last = stops_q == CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && advance && nx_last) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			start_q    <= q_data.start;
			leds_q     <= q_data.leds;
			stops_q    <= q_data.stops;
			marker_q   <= q_data.marker;
			status_q   <= q_data.status;
			led_word_q <= q_data.led_word;
		end else if (busy_q && advance) begin
			if (start_q) begin
				start_q <= 1'b0;
			end else if (leds_q != '0) begin
				leds_q <= leds_q - CNT_W'(1);
			end else if (stops_q != '0) begin
				stops_q <= stops_q - CNT_W'(1);
			end
		end
		if (advance && busy_q) begin
			out_word_q   <= nx_word;
			out_wv_q     <= nx_wv;
			out_last_q   <= nx_last;
			out_status_q <= nx_last && status_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_word_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_status_q, out_wv_q};

	// a live non-marker plan always has a word left to send
	a_plan_live: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !marker_q) |-> (start_q || (leds_q != '0) || (stops_q != '0)))
		else $error("empty plan left live");

	// the empty-chunk marker is always the last transaction of its chunk
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_wv_q) |-> out_last_q)
		else $error("marker not flagged last");

endmodule

@@ verif/tb_led_strip_frame_chunker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_strip_frame_chunker - self-checking bench for the LED strip chunker
// Streams colour commands into the block under four handshake pressure
// profiles and checks every word against a cycle-free chunk predictor.
// ----------------------------------------------------------------------------
module tb_led_strip_frame_chunker;
	import lsfc_pkg::*;

	localparam int CHUNK_WORDS = 32;
	localparam int IDLE_LIMIT  = 4000;   // cycles with no transaction on either side
	localparam int DRAIN_WAIT  = 12;     // margin past the output register before the final check

	typedef struct packed {
		logic [31:0] word;
		logic        word_valid;
		logic        last;
		logic        status;
	} strip_word_t;

	// Predicts the words of each chunk and holds them until the block sends them
	class strip_scoreboard;
		bit          start_due;
		int          sent_since_start;
		int          leds_left;
		strip_word_t expected_words[$];
		int          errors;
		int          commands;
		int          words_checked;

		function new();
			start_due        = 1'b1;
			sent_since_start = 0;
			leds_left        = 0;
			errors           = 0;
			commands         = 0;
			words_checked    = 0;
		endfunction

		function void push_word(logic [31:0] w, logic v, logic l, logic st);
			strip_word_t item;
			item.word       = w;
			item.word_valid = v;
			item.last       = l;
			item.status     = st;
			expected_words.push_back(item);
		endfunction

		function void note_command(cmd_t c);
			logic [31:0] led_word;
			int          n;
			int          space;
			int          stops;
			int          leds;
			int          total;
			int          first_led;
			bit          start;
			logic        st;
			commands++;
			led_word = {c.red, c.green, c.blue, LED_HDR, c.brightness[7:3]};
			// idle command: yields only a marker, state untouched even with a remainder
			if (c.num_leds == 16'd0 && !start_due && !c.following) begin
				push_word(32'd0, 1'b0, 1'b1, 1'b0);
				return;
			end
			n     = (leds_left != 0) ? leds_left : int'(c.num_leds);
			space = CHUNK_WORDS;
			start = start_due;
			if (start) begin
				space--;
				sent_since_start = 0;
			end
			if (c.following)
				stops = 0;
			else begin
				stops = (n + sent_since_start + 63) / 64;
				if (stops > CHUNK_WORDS - 1)
					stops = CHUNK_WORDS - 1;
			end
			if (n + stops <= space)
				leds = n;
			else begin
				leds = (n == 0) ? 0 : n - 1;
				if (leds > space)
					leds = space;
				stops = 0;
			end
			leds_left        = n - leds;
			sent_since_start = sent_since_start + leds;
			if (sent_since_start > 65535)
				sent_since_start = 65535;
			start_due = (leds_left == 0) && !c.following;
			st        = (leds_left != 0);
			total     = (start ? 1 : 0) + leds + stops;
			// empty chunk still yields a single marker
			if (total == 0) begin
				push_word(32'd0, 1'b0, 1'b1, st);
				return;
			end
			first_led = start ? 1 : 0;
			for (int k = 0; k < total; k++)
				push_word((k >= first_led && k < first_led + leds) ? led_word : 32'd0,
					1'b1, k == total - 1, (k == total - 1) ? st : 1'b0);
		endfunction

		function void check_word(logic [31:0] w, logic l, logic [1:0] usr);
			strip_word_t exp_item;
			if (expected_words.size() == 0) begin
				$error("unexpected word %h (last %b, tuser %b) with nothing pending", w, l, usr);
				errors++;
				return;
			end
			exp_item = expected_words.pop_front();
			words_checked++;
			if (w !== exp_item.word) begin
				$error("word: expected %h, got %h", exp_item.word, w);
				errors++;
			end
			if (usr[0] !== exp_item.word_valid) begin
				$error("word_valid: expected %b, got %b", exp_item.word_valid, usr[0]);
				errors++;
			end
			if (l !== exp_item.last) begin
				$error("last: expected %b, got %b", exp_item.last, l);
				errors++;
			end
			if (usr[1] !== exp_item.status) begin
				$error("status: expected %b, got %b", exp_item.status, usr[1]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;    // red[7:0], green[15:8], blue[23:16], brightness[31:24],
	                         // num_leds[47:32]
	logic        s_tuser;    // following
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;    // word
	logic        m_tlast;
	logic [1:0]  m_tuser;    // word_valid[0], status[1]

	strip_scoreboard sb = new();

	// pressure profile, percentages of cycles spent idle or stalled
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int idle_cycles    = 0;

	led_strip_frame_chunker #(
		.CHUNK_WORDS(CHUNK_WORDS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit chance(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= !chance(recv_stall_pct);
	end

	// every accepted output transaction is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_word(m_tdata, m_tlast, m_tuser);
	end

	// watchdog: a hang shows as a long run of cycles with no transaction at all
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	function automatic cmd_t colour_cmd(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic [7:0] br, logic [15:0] n, logic fol);
		cmd_t c;
		c.red        = r;
		c.green      = g;
		c.blue       = b;
		c.brightness = br;
		c.num_leds   = n;
		c.following  = fol;
		return c;
	endfunction

	// random colour; strip lengths mostly short, some spanning several chunks
	function automatic cmd_t random_cmd(logic fol);
		int          sel;
		logic [15:0] n;
		sel = $urandom_range(0, 15);
		if (sel < 2)
			n = 16'd0;
		else if (sel < 11)
			n = 16'($urandom_range(1, 40));
		else if (sel < 14)
			n = 16'($urandom_range(41, 120));
		else if (sel == 14)
			n = 16'($urandom_range(121, 400));
		else
			n = 16'($urandom_range(29, 34));   // around the chunk boundary
		return colour_cmd(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), n, fol);
	endfunction

	// Offers one command; s_tvalid stays high across back-to-back transactions
	// and is only lowered when a gap is drawn.
	task automatic send_cmd(cmd_t c);
		if (chance(send_idle_pct)) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (chance(send_idle_pct));
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {c.num_leds, c.brightness, c.blue, c.green, c.red};
		s_tuser  <= c.following;
		do @(posedge clk); while (!s_tready);
		sb.note_command(c);
	endtask

	// feed commands until the pending remainder of a long strip is used up
	task automatic drain_strip(logic fol);
		while (sb.leds_left != 0)
			send_cmd(colour_cmd(8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 16'd7, fol));
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, idle command, empty chunk, splits and remainders
		send_cmd(colour_cmd(8'hFF, 8'h00, 8'hFF, 8'hFF, 16'd1, 1'b0));
		send_cmd(colour_cmd(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0));  // start frame only
		send_cmd(colour_cmd(8'h00, 8'hFF, 8'h00, 8'h07, 16'd0, 1'b0));
		send_cmd(colour_cmd(8'h12, 8'h34, 8'h56, 8'h08, 16'd5, 1'b1));
		send_cmd(colour_cmd(8'hAA, 8'h55, 8'hAA, 8'hF8, 16'd0, 1'b0));  // idle command
		send_cmd(colour_cmd(8'h55, 8'hAA, 8'h55, 8'h80, 16'd0, 1'b1));  // empty chunk
		send_cmd(colour_cmd(8'h01, 8'h02, 8'h03, 8'h10, 16'd3, 1'b0));
		send_cmd(colour_cmd(8'hFE, 8'hFD, 8'hFC, 8'hFF, 16'd31, 1'b0)); // one LED left over
		send_cmd(colour_cmd(8'h80, 8'h80, 8'h80, 8'h40, 16'd0, 1'b0));  // idle, remainder held
		send_cmd(colour_cmd(8'h7F, 8'h7F, 8'h7F, 8'h20, 16'd77, 1'b0)); // count ignored
		send_cmd(colour_cmd(8'hC3, 8'h3C, 8'h0F, 8'hF0, 16'd30, 1'b0)); // fills chunk exactly
		send_cmd(colour_cmd(8'h0F, 8'hF0, 8'hC3, 8'h3C, 16'd32, 1'b1));
		send_cmd(colour_cmd(8'h11, 8'h22, 8'h33, 8'h44, 16'd0, 1'b1));
		send_cmd(colour_cmd(8'h99, 8'h66, 8'h99, 8'h66, 16'd64, 1'b0));
		send_cmd(colour_cmd(8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 1'b0));
		send_cmd(colour_cmd(8'hEE, 8'hDD, 8'hCC, 8'hBB, 16'd9, 1'b0));
		send_cmd(colour_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd1, 1'b0));
		send_cmd(colour_cmd(8'h5A, 8'hA5, 8'h5A, 8'hA5, 16'd33, 1'b1));
		send_cmd(colour_cmd(8'hA5, 8'h5A, 8'hA5, 8'h5A, 16'd0, 1'b0));

		// long continued strip, so the closing chunks hit the stop-word cap
		drain_strip(1'b1);
		send_cmd(colour_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd2000, 1'b1));
		drain_strip(1'b1);
		send_cmd(colour_cmd(8'h10, 8'h20, 8'h30, 8'h40, 16'd200, 1'b1));
		drain_strip(1'b1);
		send_cmd(colour_cmd(8'h40, 8'h30, 8'h20, 8'h10, 16'd40, 1'b0));
		drain_strip(1'b0);

		// random strips under each pressure profile
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			repeat (79)
				send_cmd(random_cmd($urandom_range(0, 3) == 0));
		end

		s_tvalid <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.expected_words.size() != 0) begin
			$error("%0d expected words never arrived", sb.expected_words.size());
			sb.errors++;
		end
		$display("Covered %0d colour commands, %0d words checked, under four pressure profiles",
			sb.commands, sb.words_checked);
		$display("including idle and empty chunks, split strips and capped stop words.");
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
